/* rtl/kdl_pkg.sv */
// ---------------------------------------------------------------------------
// kdl_pkg
// Shared types and codes for the keyed deque list.
// ---------------------------------------------------------------------------
package kdl_pkg;

  localparam logic [1:0] ACT_INSERT      = 2'd0;
  localparam logic [1:0] ACT_REMOVE_HEAD = 2'd1;
  localparam logic [1:0] ACT_REMOVE_TAIL = 2'd2;
  localparam logic [1:0] ACT_REMOVE_KEY  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 7;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture command, set cursor to front or back
    logic wr_front;  // write key into slot of new front
    logic wr_shift;  // write last read data one slot ahead
    logic step;      // advance cursor
    logic hit_cap;   // latch read data as removed key
    logic cnt_inc;
    logic cnt_dec;
    logic done;      // emit result with status below
    logic [1:0] st;
  } kdl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] action;
    logic empty;
    logic full;
    logic match;     // registered read data equals key
    logic last;      // cursor at final element
  } kdl_stat_t;

endpackage

/* rtl/keyed_deque_list.sv */
// ---------------------------------------------------------------------------
// keyed_deque_list
// Bounded ordered list of signed keys: insert front, remove front/back/key.
// ---------------------------------------------------------------------------
// channel   direction  handshake           fields
// command   in         start & !busy       action, key
// result    out        done (one cycle)    status, removed_key, count
//
// inserts and empty/full cases end in the decode state; remove front or back
// reads its slot and ends in the search state. remove by key searches and
// then shifts one element at a time, paced by the single ram read port and
// its registered read. busy drops as done rises. rst empties the list.
// ---------------------------------------------------------------------------
module keyed_deque_list import kdl_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              action,
  input  logic signed [KEY_W-1:0] key,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [KEY_W-1:0] removed_key,
  output logic [COUNT_W-1:0]      count
);

  kdl_cmd_t  cmd;
  kdl_stat_t stat;

  kdl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  kdl_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .action_in(action), .key_in(key),
    .cmd(cmd), .stat(stat),
    .res_valid(done), .res_status(status), .res_key(removed_key),
    .res_count(count)
  );

endmodule

/* rtl/kdl_ram.sv */
// ---------------------------------------------------------------------------
// kdl_ram
// Generic single-port-write, single-port-read ram with registered read.
// ---------------------------------------------------------------------------
module kdl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/kdl_datapath.sv */
// ---------------------------------------------------------------------------
// kdl_datapath
// Circular buffer of keys with head pointer, count, cursor and result regs.
// ---------------------------------------------------------------------------
module kdl_datapath import kdl_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             action_in,
  input  logic signed [KEY_W-1:0] key_in,
  input  kdl_cmd_t               cmd,
  output kdl_stat_t              stat,
  output logic                   res_valid,
  output logic [1:0]             res_status,
  output logic signed [KEY_W-1:0] res_key,
  output logic [COUNT_W-1:0]     res_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [AW-1:0]    head;   // physical slot of front element
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cur;    // logical position of cursor
  logic [1:0]       act;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] rdata;
  logic [KEY_W-1:0] rem;
  logic [AW-1:0]    raddr, waddr, prev_addr;
  logic [KEY_W-1:0] wdata;
  logic             we;

  // logical position to physical slot, modulo capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    begin
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
      if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
      phys = s[AW-1:0];
    end
  endfunction

  always_comb begin
    raddr     = phys(head, cur);
    prev_addr = phys(head, cur - CW'(1));
    we        = cmd.wr_front | cmd.wr_shift;
    if (cmd.wr_front) begin
      waddr = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
      wdata = key;
    end else begin
      waddr = prev_addr;
      wdata = rdata;
    end
  end

  kdl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // status to controller
  assign stat.action = act;
  assign stat.empty  = (cnt == '0);
  assign stat.full   = (cnt >= CW'(CAPACITY));
  assign stat.match  = (rdata == key);
  assign stat.last   = (cur == cnt - CW'(1));

  // command capture, cursor, pointers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.done;
      if (cmd.wr_front)
        head <= (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
      if (cmd.cnt_inc) cnt <= cnt + CW'(1);
      if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
        // removing the front advances head
        if (act == ACT_REMOVE_HEAD)
          head <= (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_in;
      key <= key_in;
      cur <= (action_in == ACT_REMOVE_TAIL) ? cnt - CW'(1) : '0;
      rem <= '0;
    end else if (cmd.step) begin
      cur <= cur + CW'(1);
    end
    if (cmd.hit_cap) rem <= rdata;
    if (cmd.done) begin
      res_status <= cmd.st;
      res_key    <= (cmd.st == ST_OK) ? (cmd.hit_cap ? rdata : rem) : '0;
      res_count  <= COUNT_W'(cmd.cnt_inc ? cnt + CW'(1)
                            : cmd.cnt_dec ? cnt - CW'(1) : cnt);
    end
  end

endmodule

/* rtl/kdl_ctrl.sv */
// ---------------------------------------------------------------------------
// kdl_ctrl
// Command sequencer: decodes the action and walks the search and shift.
// ---------------------------------------------------------------------------
module kdl_ctrl import kdl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  kdl_stat_t stat,
  output kdl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WAIT   = 6'b000100,
    S_SEARCH = 6'b001000,
    S_SWAIT  = 6'b010000,
    S_SHIFT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.action == ACT_INSERT) begin
          cmd.done = 1'b1;
          if (stat.full) cmd.st = ST_FULL;
          else begin
            cmd.wr_front = 1'b1;
            cmd.cnt_inc  = 1'b1;
            cmd.st       = ST_OK;
          end
          state_next = S_IDLE;
        end else if (stat.empty) begin
          cmd.done   = 1'b1;
          cmd.st     = ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          // cursor already set, read first slot of interest
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.action != ACT_REMOVE_KEY || stat.match) begin
          cmd.hit_cap = 1'b1;
          if (stat.action == ACT_REMOVE_HEAD || stat.action == ACT_REMOVE_TAIL
              || stat.last) begin
            cmd.done    = 1'b1;
            cmd.st      = ST_OK;
            cmd.cnt_dec = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_SWAIT;
          end
        end else if (stat.last) begin
          cmd.done   = 1'b1;
          cmd.st     = ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_SWAIT: begin
        // read data of the new cursor arrives at the end of this cycle
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        // move element at cursor one slot toward the front
        cmd.wr_shift = 1'b1;
        if (stat.last) begin
          cmd.done    = 1'b1;
          cmd.st      = ST_OK;
          cmd.cnt_dec = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_SWAIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/kdl_checker.sv */
// ---------------------------------------------------------------------------
// kdl_checker
// Port-level checks of the keyed deque list, bound to the top level.
// ---------------------------------------------------------------------------
module kdl_checker import kdl_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [1:0]              status,
  input logic signed [KEY_W-1:0] removed_key,
  input logic [COUNT_W-1:0]      count
);

  // accepted command makes block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");

  // result only ends a busy command
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("spurious done");

  // failed commands return zero key
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> removed_key == '0) else $error("key not zero");

  // empty status only with zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> count == '0) else $error("empty with count");

endmodule

bind keyed_deque_list kdl_checker u_kdl_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .removed_key(removed_key), .count(count)
);

/* dv/keyed_deque_list_checker.sv */
// ---------------------------------------------------------------------------
// keyed_deque_list_checker
// Watches the command and result ports of the keyed deque list, keeps its
// own copy of the list, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module keyed_deque_list_checker import kdl_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              action,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    done,
  input  logic [1:0]              status,
  input  logic signed [KEY_W-1:0] removed_key,
  input  logic [COUNT_W-1:0]      count,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen,
  output int                      status_hits [4]
);

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   removed_key;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic [KEY_W-1:0] shadow_keys [$];
  list_result_t     expected_results [$];

  // apply one command to the shadow list and return its result
  function automatic list_result_t apply_command(input logic [1:0] act,
                                                 input logic [KEY_W-1:0] k);
    list_result_t r;
    int           pos;
    r = '0;
    pos = -1;
    r.status = ST_OK;
    if (act == ACT_INSERT) begin
      if (shadow_keys.size() >= CAPACITY) r.status = ST_FULL;
      else shadow_keys.push_front(k);
    end else if (shadow_keys.size() == 0) begin
      r.status = ST_EMPTY;
    end else if (act == ACT_REMOVE_HEAD) begin
      r.removed_key = shadow_keys.pop_front();
    end else if (act == ACT_REMOVE_TAIL) begin
      r.removed_key = shadow_keys.pop_back();
    end else begin
      for (int i = 0; i < shadow_keys.size(); i++) begin
        if (shadow_keys[i] == k) begin
          pos = i;
          break;
        end
      end
      if (pos < 0) r.status = ST_NOTFOUND;
      else begin
        r.removed_key = shadow_keys[pos];
        shadow_keys.delete(pos);
      end
    end
    r.count = COUNT_W'(shadow_keys.size());
    return r;
  endfunction

  assign pending = expected_results.size();

  // predict on accepted items, compare on result strobes
  always @(posedge clk) begin
    list_result_t want;
    int           errs;
    errs = 0;
    if (rst) begin
      shadow_keys.delete();
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
      foreach (status_hits[i]) status_hits[i] <= 0;
    end else begin
      if (done) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          status_hits[want.status] <= status_hits[want.status] + 1;
          if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            errs++;
          end
          if (removed_key !== want.removed_key) begin
            $error("removed_key expected %0d actual %0d",
                   $signed(want.removed_key), removed_key);
            errs++;
          end
          if (count !== want.count) begin
            $error("count expected %0d actual %0d", want.count, count);
            errs++;
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
      end
      if (start && !busy) expected_results.push_back(apply_command(action, key));
    end
  end

endmodule

/* dv/keyed_deque_list_test.sv */
// ---------------------------------------------------------------------------
// keyed_deque_list_test
// Drives directed and random commands into the keyed deque list, with random
// gaps, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module keyed_deque_list_test import kdl_pkg::*;;

  localparam int unsigned CAPACITY = 64;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              action;
  logic signed [KEY_W-1:0] key;
  logic                    done;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] removed_key;
  logic [COUNT_W-1:0]      count;
  int                      fail_count;
  int                      pending;
  int                      results_seen;
  int                      status_hits [4];
  int                      list_len;
  logic [KEY_W-1:0]        recent_keys [$];

  keyed_deque_list #(.CAPACITY(CAPACITY)) dut (.*);

  keyed_deque_list_checker #(.CAPACITY(CAPACITY)) checker_i (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // issue one item, optionally preceded by a random gap
  task automatic send_item(input logic [1:0] act, input logic [KEY_W-1:0] k,
                           input bit may_gap);
    if (may_gap && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    key    <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    // track list length roughly and keep recent inserted keys for key removals
    if (act == ACT_INSERT) begin
      if (list_len < CAPACITY) list_len++;
      recent_keys.push_back(k);
      if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    end else if (list_len > 0 && act != ACT_REMOVE_KEY) list_len--;
  endtask

  // random key: half the time from a small pool so duplicates and hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(7);
    endcase
  endfunction

  initial begin
    logic [1:0]       act;
    logic [KEY_W-1:0] k;
    bit               gaps;
    int               fill_bias;
    rst    <= 1'b1;
    start  <= 1'b0;
    action <= ACT_INSERT;
    key    <= '0;
    list_len = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, duplicates, not found
    send_item(ACT_REMOVE_HEAD, 32'h0, 0);
    send_item(ACT_REMOVE_TAIL, 32'hffff_ffff, 0);
    send_item(ACT_REMOVE_KEY, 32'h5, 0);
    send_item(ACT_INSERT, 32'h8000_0000, 0);
    send_item(ACT_INSERT, 32'h7fff_ffff, 0);
    send_item(ACT_INSERT, 32'hffff_ffff, 0);
    send_item(ACT_INSERT, 32'h0, 0);
    send_item(ACT_INSERT, 32'h7fff_ffff, 0);
    send_item(ACT_REMOVE_KEY, 32'h1234_5678, 0);
    send_item(ACT_REMOVE_KEY, 32'h7fff_ffff, 0);
    send_item(ACT_REMOVE_KEY, 32'h8000_0000, 0);
    send_item(ACT_REMOVE_HEAD, 32'h0, 0);
    send_item(ACT_REMOVE_TAIL, 32'h0, 0);
    send_item(ACT_REMOVE_TAIL, 32'h0, 0);
    send_item(ACT_REMOVE_TAIL, 32'h0, 0);
    // fill past capacity, then match at the back end and at the front
    for (int i = 0; i <= CAPACITY; i++) send_item(ACT_INSERT, i, 0);
    send_item(ACT_REMOVE_KEY, 32'h0, 0);
    send_item(ACT_REMOVE_KEY, CAPACITY - 1, 0);

    // random: phases drift between filling and draining
    for (int n = 0; n < 1750; n++) begin
      if (n % 250 == 0) fill_bias = $urandom_range(20, 80);
      gaps = !(n >= 600 && n < 900);
      if ($urandom_range(99) < fill_bias) act = ACT_INSERT;
      else act = 2'($urandom_range(1, 3));
      if (act == ACT_REMOVE_KEY && recent_keys.size() > 0 && $urandom_range(1))
        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else k = pick_key();
      send_item(act, k, gaps);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (2 * CAPACITY + 10) @(posedge clk);
    $display("results checked: %0d", results_seen);
    $display("status ok %0d empty %0d not found %0d full %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY],
             status_hits[ST_NOTFOUND], status_hits[ST_FULL]);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/kdl_pkg.sv
rtl/kdl_ram.sv
rtl/kdl_datapath.sv
rtl/kdl_ctrl.sv
rtl/keyed_deque_list.sv
rtl/kdl_checker.sv
dv/keyed_deque_list_checker.sv
dv/keyed_deque_list_test.sv
